FILE: sv/plps_pkg.sv
package plps_pkg;

    // Fixed-point unit and pipeline geometry.
    localparam logic [14:0] ONE_Q14 = 15'd16384;
    localparam logic [11:0] OUT_MAX = 12'd4095;

    localparam int SQ1_N = 25;   // root bits of |D| and |V| (Q.8)
    localparam int SQ2_N = 23;   // root bits of |R| (Q14)
    localparam int DV_N  = 15;   // quotient bits of each long division
    localparam int POW_N = 8;    // exponent bits

    localparam int ST_IN   = 0;
    localparam int ST_D    = 1;
    localparam int ST_PROD = 2;
    localparam int ST_SUM  = 3;
    localparam int ST_SQ1  = 4;
    localparam int ST_DV1P = ST_SQ1 + SQ1_N;
    localparam int ST_DV1  = ST_DV1P + 1;
    localparam int ST_L    = ST_DV1 + DV_N;
    localparam int ST_LN_P = ST_L + 1;
    localparam int ST_LN_S = ST_L + 2;
    localparam int ST_LN   = ST_L + 3;
    localparam int ST_RN_P = ST_L + 4;
    localparam int ST_RN_T = ST_L + 5;
    localparam int ST_R    = ST_L + 6;
    localparam int ST_R_P  = ST_L + 7;
    localparam int ST_R_S  = ST_L + 8;
    localparam int ST_SQ2  = ST_R_S + 1;
    localparam int ST_DEN  = ST_SQ2 + SQ2_N;
    localparam int ST_DV2P = ST_DEN + 1;
    localparam int ST_DV2  = ST_DV2P + 1;
    localparam int ST_FS   = ST_DV2 + DV_N;
    localparam int ST_POW  = ST_FS + 1;
    localparam int ST_CH1  = ST_POW + POW_N;
    localparam int ST_CH2  = ST_CH1 + 1;
    localparam int N_STG   = ST_CH2 + 1;

    // Register map, word index.
    localparam logic [2:0] REG_LIGHT_RED   = 3'd0;
    localparam logic [2:0] REG_LIGHT_GREEN = 3'd1;
    localparam logic [2:0] REG_LIGHT_BLUE  = 3'd2;
    localparam logic [2:0] REG_LIGHT_X     = 3'd3;
    localparam logic [2:0] REG_LIGHT_Y     = 3'd4;
    localparam logic [2:0] REG_LIGHT_Z     = 3'd5;
    localparam logic [2:0] REG_SPEC_EXP    = 3'd6;

    // Everything one request carries down the pipeline. Fields are filled in
    // as the request moves along; unused ones fall away in synthesis.
    typedef struct packed {
        logic [2:0][10:0] kd;
        logic [2:0][10:0] ks;
        logic [2:0][15:0] p;
        logic [2:0][15:0] n;
        logic [2:0][16:0] d;
        logic [2:0][33:0] pr_dd;
        logic [2:0][31:0] pr_pp;
        logic [2:0][32:0] pr_dn;
        logic [34:0]      dot;
        logic [49:0]      sa_rad;
        logic [26:0]      sa_rem;
        logic [24:0]      sa_root;
        logic [49:0]      sb_rad;
        logic [26:0]      sb_rem;
        logic [24:0]      sb_root;
        logic [3:0][41:0] dv_rem;
        logic [3:0][14:0] dv_q;
        logic [2:0]       dv_neg;
        logic             fd_ovf;
        logic             dot_pos;
        logic             md_nz;
        logic [14:0]      fd;
        logic [2:0][15:0] l;
        logic [2:0][31:0] ln_p;
        logic [33:0]      ln_s;
        logic [17:0]      ln;
        logic [2:0][34:0] rn_p;
        logic [2:0][20:0] rn_t;
        logic [2:0][21:0] r;
        logic [2:0][43:0] rr;
        logic [2:0][38:0] vrp;
        logic [40:0]      vr;
        logic [45:0]      sc_rad;
        logic [24:0]      sc_rem;
        logic [22:0]      sc_root;
        logic [47:0]      den;
        logic             fs_en;
        logic [62:0]      f_rem;
        logic [14:0]      f_q;
        logic             f_ovf;
        logic [14:0]      pw_res;
        logic [14:0]      pw_base;
        logic [2:0][22:0] lk;
        logic [2:0][22:0] lks;
        logic [2:0][11:0] o_d;
        logic [2:0][11:0] o_s;
    } t_ctx;

endpackage

FILE: sv/point_light_phong_shading.sv
// The pipeline holds up to 105 requests in flight. Throughput: one request per cycle
// while no result is held. Three square roots (25 and 23 stages) and five
// 15-stage long divisions are unrolled into stages, so nothing iterates in place.
// A stall on the result side freezes every stage at once; nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline, zeroes the light, exponent one.
module point_light_phong_shading
    import plps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_point_x,
    input  logic [15:0] i_point_y,
    input  logic [15:0] i_point_z,
    input  logic [15:0] i_normal_x,
    input  logic [15:0] i_normal_y,
    input  logic [15:0] i_normal_z,
    input  logic [10:0] i_diffuse_red,
    input  logic [10:0] i_diffuse_green,
    input  logic [10:0] i_diffuse_blue,
    input  logic [10:0] i_specular_red,
    input  logic [10:0] i_specular_green,
    input  logic [10:0] i_specular_blue,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_out_diffuse_red,
    output logic [11:0] o_out_diffuse_green,
    output logic [11:0] o_out_diffuse_blue,
    output logic [11:0] o_out_specular_red,
    output logic [11:0] o_out_specular_green,
    output logic [11:0] o_out_specular_blue
);

    logic [11:0] r_light_col [3];
    logic [15:0] r_light_pos [3];
    logic [7:0]  r_spec_exp;

    t_ctx             r_ctx [N_STG];
    t_ctx             n_ctx [N_STG];
    logic [N_STG-1:0] r_vld;
    logic             w_adv;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_col[0] <= '0;
            r_light_col[1] <= '0;
            r_light_col[2] <= '0;
            r_light_pos[0] <= '0;
            r_light_pos[1] <= '0;
            r_light_pos[2] <= '0;
            r_spec_exp     <= 8'd1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_LIGHT_RED:   r_light_col[0] <= pwdata[11:0];
                REG_LIGHT_GREEN: r_light_col[1] <= pwdata[11:0];
                REG_LIGHT_BLUE:  r_light_col[2] <= pwdata[11:0];
                REG_LIGHT_X:     r_light_pos[0] <= pwdata[15:0];
                REG_LIGHT_Y:     r_light_pos[1] <= pwdata[15:0];
                REG_LIGHT_Z:     r_light_pos[2] <= pwdata[15:0];
                REG_SPEC_EXP:    r_spec_exp     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_LIGHT_RED:   prdata = {20'd0, r_light_col[0]};
            REG_LIGHT_GREEN: prdata = {20'd0, r_light_col[1]};
            REG_LIGHT_BLUE:  prdata = {20'd0, r_light_col[2]};
            REG_LIGHT_X:     prdata = {16'd0, r_light_pos[0]};
            REG_LIGHT_Y:     prdata = {16'd0, r_light_pos[1]};
            REG_LIGHT_Z:     prdata = {16'd0, r_light_pos[2]};
            REG_SPEC_EXP:    prdata = {24'd0, r_spec_exp};
            default:         prdata = '0;
        endcase
    end

    // The whole pipeline moves unless the result register is held.
    assign w_adv   = !(r_vld[N_STG-1] && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_vld[N_STG-1];

    assign o_out_diffuse_red    = r_ctx[N_STG-1].o_d[0];
    assign o_out_diffuse_green  = r_ctx[N_STG-1].o_d[1];
    assign o_out_diffuse_blue   = r_ctx[N_STG-1].o_d[2];
    assign o_out_specular_red   = r_ctx[N_STG-1].o_s[0];
    assign o_out_specular_green = r_ctx[N_STG-1].o_s[1];
    assign o_out_specular_blue  = r_ctx[N_STG-1].o_s[2];

    for (genvar s = 0; s < N_STG; s++) begin : g_stg

        if (s == ST_IN) begin : g_in
            always_comb begin
                n_ctx[s]       = '0;
                n_ctx[s].p[0]  = i_point_x;
                n_ctx[s].p[1]  = i_point_y;
                n_ctx[s].p[2]  = i_point_z;
                n_ctx[s].n[0]  = i_normal_x;
                n_ctx[s].n[1]  = i_normal_y;
                n_ctx[s].n[2]  = i_normal_z;
                n_ctx[s].kd[0] = i_diffuse_red;
                n_ctx[s].kd[1] = i_diffuse_green;
                n_ctx[s].kd[2] = i_diffuse_blue;
                n_ctx[s].ks[0] = i_specular_red;
                n_ctx[s].ks[1] = i_specular_green;
                n_ctx[s].ks[2] = i_specular_blue;
            end
        end else if (s == ST_D) begin : g_d
            always_comb begin
                t_ctx              c;
                logic signed [16:0] lp [3];
                logic signed [16:0] pp [3];
                c = r_ctx[s-1];
                for (int i = 0; i < 3; i++) begin
                    lp[i]  = $signed(r_light_pos[i]);
                    pp[i]  = $signed(c.p[i]);
                    c.d[i] = lp[i] - pp[i];
                end
                n_ctx[s] = c;
            end
        end else if (s == ST_PROD) begin : g_prod
            always_comb begin
                t_ctx              c;
                logic signed [33:0] a [3];
                logic signed [31:0] b [3];
                logic signed [32:0] e [3];
                logic signed [32:0] f [3];
                c = r_ctx[s-1];
                for (int i = 0; i < 3; i++) begin
                    a[i]       = $signed(c.d[i]);
                    b[i]       = $signed(c.p[i]);
                    e[i]       = $signed(c.d[i]);
                    f[i]       = $signed(c.n[i]);
                    c.pr_dd[i] = a[i] * a[i];
                    c.pr_pp[i] = b[i] * b[i];
                    c.pr_dn[i] = e[i] * f[i];
                end
                n_ctx[s] = c;
            end
        end else if (s == ST_SUM) begin : g_sum
            always_comb begin
                t_ctx              c;
                logic [33:0]        d2;
                logic [31:0]        p2;
                logic signed [34:0] t [3];
                c  = r_ctx[s-1];
                d2 = c.pr_dd[0] + c.pr_dd[1] + c.pr_dd[2];
                p2 = c.pr_pp[0] + c.pr_pp[1] + c.pr_pp[2];
                for (int i = 0; i < 3; i++) begin
                    t[i] = $signed(c.pr_dn[i]);
                end
                c.dot     = t[0] + t[1] + t[2];
                c.sa_rad  = {d2, 16'd0};
                c.sa_rem  = '0;
                c.sa_root = '0;
                c.sb_rad  = {2'd0, p2, 16'd0};
                c.sb_rem  = '0;
                c.sb_root = '0;
                n_ctx[s]  = c;
            end
        end else if (s >= ST_SQ1 && s < ST_DV1P) begin : g_sq1
            // One root bit of |D| and of |V| per stage.
            always_comb begin
                t_ctx        c;
                logic [26:0] ra;
                logic [26:0] ta;
                logic [26:0] rb;
                logic [26:0] tb;
                c  = r_ctx[s-1];
                ra = {c.sa_rem[24:0], c.sa_rad[49:48]};
                ta = {c.sa_root, 2'b01};
                rb = {c.sb_rem[24:0], c.sb_rad[49:48]};
                tb = {c.sb_root, 2'b01};
                if (ra >= ta) begin
                    c.sa_rem  = ra - ta;
                    c.sa_root = {c.sa_root[23:0], 1'b1};
                end else begin
                    c.sa_rem  = ra;
                    c.sa_root = {c.sa_root[23:0], 1'b0};
                end
                if (rb >= tb) begin
                    c.sb_rem  = rb - tb;
                    c.sb_root = {c.sb_root[23:0], 1'b1};
                end else begin
                    c.sb_rem  = rb;
                    c.sb_root = {c.sb_root[23:0], 1'b0};
                end
                c.sa_rad = {c.sa_rad[47:0], 2'b00};
                c.sb_rad = {c.sb_rad[47:0], 2'b00};
                n_ctx[s] = c;
            end
        end else if (s == ST_DV1P) begin : g_dv1p
            // Lane 0 divides for the diffuse factor, lanes 1 to 3 normalise D.
            always_comb begin
                t_ctx        c;
                logic [41:0] num;
                logic [16:0] ad;
                c         = r_ctx[s-1];
                c.md_nz   = |c.sa_root;
                c.dot_pos = !c.dot[34] && (|c.dot);
                num       = c.dot_pos ? {c.dot[33:0], 8'd0} : '0;
                c.fd_ovf  = num >= {2'd0, c.sa_root, 15'd0};
                c.dv_rem[0] = num;
                c.dv_q[0]   = '0;
                for (int i = 0; i < 3; i++) begin
                    ad = c.d[i][16] ? (17'd0 - c.d[i]) : c.d[i];
                    c.dv_neg[i]   = c.d[i][16];
                    c.dv_rem[i+1] = {3'd0, ad, 22'd0};
                    c.dv_q[i+1]   = '0;
                end
                n_ctx[s] = c;
            end
        end else if (s >= ST_DV1 && s < ST_L) begin : g_dv1
            localparam int B = DV_N - 1 - (s - ST_DV1);
            always_comb begin
                t_ctx        c;
                logic [41:0] dd;
                c  = r_ctx[s-1];
                dd = {17'd0, c.sa_root} << B;
                for (int k = 0; k < 4; k++) begin
                    if (c.dv_rem[k] >= dd) begin
                        c.dv_rem[k] = c.dv_rem[k] - dd;
                        c.dv_q[k]   = {c.dv_q[k][13:0], 1'b1};
                    end else begin
                        c.dv_q[k]   = {c.dv_q[k][13:0], 1'b0};
                    end
                end
                n_ctx[s] = c;
            end
        end else if (s == ST_L) begin : g_l
            always_comb begin
                t_ctx        c;
                logic [15:0] q;
                c = r_ctx[s-1];
                for (int i = 0; i < 3; i++) begin
                    q      = {1'b0, c.dv_q[i+1]};
                    c.l[i] = c.dv_neg[i] ? (16'd0 - q) : q;
                end
                if (!(c.md_nz && c.dot_pos)) begin
                    c.fd = '0;
                end else if (c.fd_ovf || c.dv_q[0] > ONE_Q14) begin
                    c.fd = ONE_Q14;
                end else begin
                    c.fd = c.dv_q[0];
                end
                n_ctx[s] = c;
            end
        end else if (s == ST_LN_P) begin : g_lnp
            always_comb begin
                t_ctx              c;
                logic signed [31:0] a [3];
                logic signed [31:0] b [3];
                c = r_ctx[s-1];
                for (int i = 0; i < 3; i++) begin
                    a[i]      = $signed(c.l[i]);
                    b[i]      = $signed(c.n[i]);
                    c.ln_p[i] = a[i] * b[i];
                end
                n_ctx[s] = c;
            end
        end else if (s == ST_LN_S) begin : g_lns
            always_comb begin
                t_ctx              c;
                logic signed [33:0] t [3];
                c = r_ctx[s-1];
                for (int i = 0; i < 3; i++) begin
                    t[i] = $signed(c.ln_p[i]);
                end
                c.ln_s   = t[0] + t[1] + t[2];
                n_ctx[s] = c;
            end
        end else if (s == ST_LN) begin : g_ln
            // Shift that rounds toward zero: bias negative values first.
            always_comb begin
                t_ctx              c;
                logic signed [33:0] x;
                logic signed [33:0] y;
                c = r_ctx[s-1];
                x = $signed(c.ln_s);
                y = x + (c.ln_s[33] ? 34'sd16383 : 34'sd0);
                y = y >>> 14;
                c.ln     = y[17:0];
                n_ctx[s] = c;
            end
        end else if (s == ST_RN_P) begin : g_rnp
            always_comb begin
                t_ctx              c;
                logic signed [34:0] a;
                logic signed [34:0] b [3];
                logic signed [34:0] m [3];
                c = r_ctx[s-1];
                a = $signed(c.ln);
                for (int i = 0; i < 3; i++) begin
                    b[i]      = $signed(c.n[i]);
                    m[i]      = a * b[i];
                    c.rn_p[i] = m[i] <<< 1;
                end
                n_ctx[s] = c;
            end
        end else if (s == ST_RN_T) begin : g_rnt
            always_comb begin
                t_ctx              c;
                logic signed [34:0] y [3];
                c = r_ctx[s-1];
                for (int i = 0; i < 3; i++) begin
                    y[i]      = $signed(c.rn_p[i]) +
                                (c.rn_p[i][34] ? 35'sd16383 : 35'sd0);
                    y[i]      = y[i] >>> 14;
                    c.rn_t[i] = y[i][20:0];
                end
                n_ctx[s] = c;
            end
        end else if (s == ST_R) begin : g_r
            always_comb begin
                t_ctx              c;
                logic signed [21:0] a [3];
                logic signed [21:0] b [3];
                c = r_ctx[s-1];
                for (int i = 0; i < 3; i++) begin
                    a[i]   = $signed(c.rn_t[i]);
                    b[i]   = $signed(c.l[i]);
                    c.r[i] = a[i] - b[i];
                end
                n_ctx[s] = c;
            end
        end else if (s == ST_R_P) begin : g_rp
            // |R| squared, and V.R with V the negated point.
            always_comb begin
                t_ctx              c;
                logic signed [43:0] a [3];
                logic signed [38:0] v [3];
                logic signed [38:0] w [3];
                c = r_ctx[s-1];
                for (int i = 0; i < 3; i++) begin
                    a[i]     = $signed(c.r[i]);
                    v[i]     = $signed(c.p[i]);
                    v[i]     = 39'sd0 - v[i];
                    w[i]     = $signed(c.r[i]);
                    c.rr[i]  = a[i] * a[i];
                    c.vrp[i] = v[i] * w[i];
                end
                n_ctx[s] = c;
            end
        end else if (s == ST_R_S) begin : g_rs
            always_comb begin
                t_ctx              c;
                logic signed [40:0] t [3];
                c = r_ctx[s-1];
                for (int i = 0; i < 3; i++) begin
                    t[i] = $signed(c.vrp[i]);
                end
                c.vr      = t[0] + t[1] + t[2];
                c.sc_rad  = {2'd0, c.rr[0]} + {2'd0, c.rr[1]} + {2'd0, c.rr[2]};
                c.sc_rem  = '0;
                c.sc_root = '0;
                n_ctx[s]  = c;
            end
        end else if (s >= ST_SQ2 && s < ST_DEN) begin : g_sq2
            always_comb begin
                t_ctx        c;
                logic [24:0] rc;
                logic [24:0] tc;
                c  = r_ctx[s-1];
                rc = {c.sc_rem[22:0], c.sc_rad[45:44]};
                tc = {c.sc_root, 2'b01};
                if (rc >= tc) begin
                    c.sc_rem  = rc - tc;
                    c.sc_root = {c.sc_root[21:0], 1'b1};
                end else begin
                    c.sc_rem  = rc;
                    c.sc_root = {c.sc_root[21:0], 1'b0};
                end
                c.sc_rad = {c.sc_rad[43:0], 2'b00};
                n_ctx[s] = c;
            end
        end else if (s == ST_DEN) begin : g_den
            always_comb begin
                t_ctx        c;
                logic [47:0] a;
                logic [47:0] b;
                c = r_ctx[s-1];
                a = {23'd0, c.sb_root};
                b = {25'd0, c.sc_root};
                c.den   = a * b;
                c.fs_en = c.md_nz && (|c.sb_root) && (|c.sc_root) &&
                          !c.vr[40] && (|c.vr);
                n_ctx[s] = c;
            end
        end else if (s == ST_DV2P) begin : g_dv2p
            always_comb begin
                t_ctx c;
                c = r_ctx[s-1];
                c.f_rem  = c.fs_en ? {1'b0, c.vr[39:0], 22'd0} : '0;
                c.f_ovf  = c.f_rem >= {c.den, 15'd0};
                c.f_q    = '0;
                n_ctx[s] = c;
            end
        end else if (s >= ST_DV2 && s < ST_FS) begin : g_dv2
            localparam int B = DV_N - 1 - (s - ST_DV2);
            always_comb begin
                t_ctx        c;
                logic [62:0] dd;
                c  = r_ctx[s-1];
                dd = {15'd0, c.den} << B;
                if (c.f_rem >= dd) begin
                    c.f_rem = c.f_rem - dd;
                    c.f_q   = {c.f_q[13:0], 1'b1};
                end else begin
                    c.f_q   = {c.f_q[13:0], 1'b0};
                end
                n_ctx[s] = c;
            end
        end else if (s == ST_FS) begin : g_fs
            always_comb begin
                t_ctx c;
                c = r_ctx[s-1];
                if (!c.fs_en) begin
                    c.pw_base = '0;
                end else if (c.f_ovf || c.f_q > ONE_Q14) begin
                    c.pw_base = ONE_Q14;
                end else begin
                    c.pw_base = c.f_q;
                end
                c.pw_res = ONE_Q14;
                n_ctx[s] = c;
            end
        end else if (s >= ST_POW && s < ST_CH1) begin : g_pow
            // Square and multiply, one exponent bit per stage from the lowest.
            localparam int K = s - ST_POW;
            always_comb begin
                t_ctx        c;
                logic [29:0] mr;
                logic [29:0] mb;
                c  = r_ctx[s-1];
                mr = {15'd0, c.pw_res} * {15'd0, c.pw_base};
                mb = {15'd0, c.pw_base} * {15'd0, c.pw_base};
                if (r_spec_exp[K]) begin
                    c.pw_res = mr[28:14];
                end
                c.pw_base = mb[28:14];
                n_ctx[s]  = c;
            end
        end else if (s == ST_CH1) begin : g_ch1
            always_comb begin
                t_ctx c;
                c = r_ctx[s-1];
                for (int i = 0; i < 3; i++) begin
                    c.lk[i]  = {11'd0, r_light_col[i]} * {12'd0, c.kd[i]};
                    c.lks[i] = {11'd0, r_light_col[i]} * {12'd0, c.ks[i]};
                end
                n_ctx[s] = c;
            end
        end else begin : g_ch2
            always_comb begin
                t_ctx        c;
                logic [37:0] md;
                logic [37:0] ms;
                c = r_ctx[s-1];
                for (int i = 0; i < 3; i++) begin
                    md = {15'd0, c.lk[i]} * {23'd0, c.fd};
                    ms = {15'd0, c.lks[i]} * {23'd0, c.pw_res};
                    c.o_d[i] = (md[37:24] > {2'd0, OUT_MAX}) ? OUT_MAX : md[35:24];
                    c.o_s[i] = (ms[37:24] > {2'd0, OUT_MAX}) ? OUT_MAX : ms[35:24];
                end
                n_ctx[s] = c;
            end
        end

        if (s == 0) begin : g_v0
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (w_adv) begin
                    r_vld[s] <= i_valid;
                end
            end
        end else begin : g_vn
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (w_adv) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_ctx[s] <= n_ctx[s];
            end
        end
    end

    // A held result freezes every stage.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline moved while the result was held");

    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_DV1P-1] |->
            r_ctx[ST_DV1P-1].sa_rem <= {1'b0, r_ctx[ST_DV1P-1].sa_root, 1'b0})
        else $error("square root remainder out of bound");

    a_fd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_L] |-> r_ctx[ST_L].fd <= ONE_Q14)
        else $error("diffuse factor above one");

    a_fd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_L] && !r_ctx[ST_L].md_nz |-> r_ctx[ST_L].fd == 15'd0)
        else $error("diffuse factor set with light at the point");

    a_pow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_CH1-1] |-> r_ctx[ST_CH1-1].pw_res <= ONE_Q14)
        else $error("specular power above one");

endmodule

FILE: tb/tb_point_light_phong_shading.sv
`timescale 1ns / 100ps

module tb_point_light_phong_shading;
    import plps_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [15:0] px, py, pz, nx, ny, nz;
        logic [10:0] kd [3];
        logic [10:0] ks [3];
    } t_shade_req;

    typedef struct {
        logic [11:0] dif [3];
        logic [11:0] spc [3];
    } t_shade_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid, o_stall, o_valid, i_stall;
    logic [15:0] i_point_x, i_point_y, i_point_z, i_normal_x, i_normal_y, i_normal_z;
    logic [10:0] i_diffuse_red, i_diffuse_green, i_diffuse_blue;
    logic [10:0] i_specular_red, i_specular_green, i_specular_blue;
    logic [11:0] o_out_diffuse_red, o_out_diffuse_green, o_out_diffuse_blue;
    logic [11:0] o_out_specular_red, o_out_specular_green, o_out_specular_blue;

    point_light_phong_shading uut (.*);

    // Shadow copy of the light registers.
    logic [11:0] lt_col [3];
    logic signed [15:0] lt_pos [3];
    logic [7:0]  lt_exp;

    t_shade_res  shade_queue [$];
    int          n_errors = 0;
    int          idle_cycles;
    int          send_idle_pct, stall_pct;
    bit          hold_off;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint trunc_div(input longint n, input longint d);
        longint q;
        q = (n < 0 ? -n : n) / d;
        return n < 0 ? -q : q;
    endfunction

    function automatic logic [11:0] channel_out(input longint lc, input longint k,
                                                input longint f);
        longint v;
        v = (lc * k * f) >>> 24;
        return v > OUT_MAX ? OUT_MAX : v[11:0];
    endfunction

    function automatic t_shade_res shade_point(input t_shade_req rq);
        t_shade_res res;
        longint p [3];
        longint n [3];
        longint d [3];
        longint l [3];
        longint r [3];
        longint d2, md, dot, ln, mv, mr, vr, fd, fs, sp, base;
        logic [7:0] e;
        fd = 0;
        fs = 0;
        p[0] = $signed(rq.px); p[1] = $signed(rq.py); p[2] = $signed(rq.pz);
        n[0] = $signed(rq.nx); n[1] = $signed(rq.ny); n[2] = $signed(rq.nz);
        for (int i = 0; i < 3; i++) d[i] = longint'(lt_pos[i]) - p[i];
        d2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        md = int_sqrt(d2 << 16);
        if (md != 0) begin
            dot = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
            if (dot > 0) begin
                fd = (dot << 8) / md;
                if (fd > ONE_Q14) fd = ONE_Q14;
            end
            for (int i = 0; i < 3; i++) l[i] = trunc_div(d[i] * (64'sd1 << 22), md);
            ln = trunc_div(l[0] * n[0] + l[1] * n[1] + l[2] * n[2], ONE_Q14);
            for (int i = 0; i < 3; i++) r[i] = trunc_div(2 * ln * n[i], ONE_Q14) - l[i];
            mv = int_sqrt((p[0] * p[0] + p[1] * p[1] + p[2] * p[2]) << 16);
            mr = int_sqrt(r[0] * r[0] + r[1] * r[1] + r[2] * r[2]);
            if (mv != 0 && mr != 0) begin
                vr = -(p[0] * r[0] + p[1] * r[1] + p[2] * r[2]);
                if (vr > 0) begin
                    fs = longint'((64'(vr) << 22) / 64'(mv * mr));
                    if (fs > ONE_Q14) fs = ONE_Q14;
                end
            end
        end
        sp = ONE_Q14;
        base = fs;
        e = lt_exp;
        while (e != 0) begin
            if (e[0]) sp = (sp * base) >>> 14;
            base = (base * base) >>> 14;
            e >>= 1;
        end
        for (int c = 0; c < 3; c++) begin
            res.dif[c] = channel_out(lt_col[c], rq.kd[c], fd);
            res.spc[c] = channel_out(lt_col[c], rq.ks[c], sp);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [11:0] got,
                                   input logic [11:0] want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_LIGHT_RED:   lt_col[0] = val[11:0];
            REG_LIGHT_GREEN: lt_col[1] = val[11:0];
            REG_LIGHT_BLUE:  lt_col[2] = val[11:0];
            REG_LIGHT_X:     lt_pos[0] = val[15:0];
            REG_LIGHT_Y:     lt_pos[1] = val[15:0];
            REG_LIGHT_Z:     lt_pos[2] = val[15:0];
            REG_SPEC_EXP:    lt_exp    = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_light(input logic [11:0] r, input logic [11:0] g, input logic [11:0] b,
                             input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
                             input logic [7:0] e);
        write_reg(REG_LIGHT_RED, 32'(r));
        write_reg(REG_LIGHT_GREEN, 32'(g));
        write_reg(REG_LIGHT_BLUE, 32'(b));
        write_reg(REG_LIGHT_X, 32'(x));
        write_reg(REG_LIGHT_Y, 32'(y));
        write_reg(REG_LIGHT_Z, 32'(z));
        write_reg(REG_SPEC_EXP, 32'(e));
    endtask

    // Drives one request at the falling edge, holds it until accepted and then
    // queues the given expected result.
    task automatic send_expected(input t_shade_req rq, input t_shade_res want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_point_x = rq.px; i_point_y = rq.py; i_point_z = rq.pz;
        i_normal_x = rq.nx; i_normal_y = rq.ny; i_normal_z = rq.nz;
        i_diffuse_red = rq.kd[0]; i_diffuse_green = rq.kd[1]; i_diffuse_blue = rq.kd[2];
        i_specular_red = rq.ks[0]; i_specular_green = rq.ks[1]; i_specular_blue = rq.ks[2];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        shade_queue.push_back(want);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic send_request(input t_shade_req rq);
        send_expected(rq, shade_point(rq));
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(4096)) - 2048);
            default: return 16'($signed($urandom_range(1024)) - 512);
        endcase
    endfunction

    function automatic t_shade_req rand_request();
        t_shade_req rq;
        int a, b;
        rq.px = rand_coord(); rq.py = rand_coord(); rq.pz = rand_coord();
        if ($urandom_range(9) == 0) begin
            rq.nx = 16'($urandom); rq.ny = 16'($urandom); rq.nz = 16'($urandom);
        end else begin
            // Roughly unit normal: two random components and the rest to fill.
            a = $signed($urandom_range(22000)) - 11000;
            b = $signed($urandom_range(22000)) - 11000;
            rq.nx = 16'(a);
            rq.ny = 16'(b);
            rq.nz = 16'(int'($sqrt(real'(268435456 - a * a - b * b))));
            if ($urandom_range(1)) rq.nz = -rq.nz;
        end
        for (int c = 0; c < 3; c++) begin
            rq.kd[c] = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(1024));
            rq.ks[c] = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(1024));
        end
        return rq;
    endfunction

    function automatic t_shade_req make_request(input logic [15:0] px, input logic [15:0] py,
            input logic [15:0] pz, input logic [15:0] nx, input logic [15:0] ny,
            input logic [15:0] nz, input logic [10:0] kd, input logic [10:0] ks);
        t_shade_req rq;
        rq.px = px; rq.py = py; rq.pz = pz;
        rq.nx = nx; rq.ny = ny; rq.nz = nz;
        for (int c = 0; c < 3; c++) begin
            rq.kd[c] = kd;
            rq.ks[c] = ks;
        end
        return rq;
    endfunction

    task automatic drain();
        while (shade_queue.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    // Result side: random stalls, plus one long hold-off to fill the pipeline.
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_shade_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (shade_queue.size() == 0) begin
                report_mismatch("result with nothing queued, diffuse red",
                                o_out_diffuse_red, 12'd0);
            end else begin
                want = shade_queue.pop_front();
                if (o_out_diffuse_red !== want.dif[0])
                    report_mismatch("diffuse red", o_out_diffuse_red, want.dif[0]);
                if (o_out_diffuse_green !== want.dif[1])
                    report_mismatch("diffuse green", o_out_diffuse_green, want.dif[1]);
                if (o_out_diffuse_blue !== want.dif[2])
                    report_mismatch("diffuse blue", o_out_diffuse_blue, want.dif[2]);
                if (o_out_specular_red !== want.spc[0])
                    report_mismatch("specular red", o_out_specular_red, want.spc[0]);
                if (o_out_specular_green !== want.spc[1])
                    report_mismatch("specular green", o_out_specular_green, want.spc[1]);
                if (o_out_specular_blue !== want.spc[2])
                    report_mismatch("specular blue", o_out_specular_blue, want.spc[2]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_shade_req dir_table [$];
        t_shade_res fixed;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_valid = 1'b0;
        i_point_x = '0; i_point_y = '0; i_point_z = '0;
        i_normal_x = '0; i_normal_y = '0; i_normal_z = '0;
        i_diffuse_red = '0; i_diffuse_green = '0; i_diffuse_blue = '0;
        i_specular_red = '0; i_specular_green = '0; i_specular_blue = '0;
        lt_col = '{default: '0};
        lt_pos = '{default: '0};
        lt_exp = 8'd1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // With the light dark after reset every channel must read zero.
        fixed.dif = '{default: '0};
        fixed.spc = '{default: '0};
        send_expected(make_request(16'h0100, 16'h0, 16'hFC00, 16'h0, 16'h0, 16'h4000,
                                   11'd1024, 11'd1024), fixed);
        drain();

        set_light(12'hFFF, 12'd1024, 12'd0, 16'h0000, 16'h0400, 16'h0000, 8'd1);
        // Light at the point, point at the camera, normal along and against the
        // light, oversized normals, degenerate reflection and field extremes.
        dir_table.push_back(make_request(16'h0000, 16'h0400, 16'h0000, 16'h0, 16'h4000,
                                         16'h0, 11'd1024, 11'd1024));
        dir_table.push_back(make_request(16'h0000, 16'h0000, 16'h0000, 16'h0, 16'h4000,
                                         16'h0, 11'd1024, 11'd1024));
        dir_table.push_back(make_request(16'h0000, 16'h0000, 16'hFC00, 16'h0, 16'h4000,
                                         16'h0, 11'd1024, 11'd1024));
        dir_table.push_back(make_request(16'h0000, 16'h0000, 16'hFC00, 16'h0, 16'hC000,
                                         16'h0, 11'd1024, 11'd1024));
        dir_table.push_back(make_request(16'h0100, 16'h0000, 16'hFC00, 16'h7FFF, 16'h7FFF,
                                         16'h7FFF, 11'h7FF, 11'h7FF));
        dir_table.push_back(make_request(16'h0000, 16'hFC00, 16'h0000, 16'h0, 16'h4000,
                                         16'h0, 11'd1024, 11'd1024));
        dir_table.push_back(make_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                                         16'h8000, 11'h7FF, 11'h000));
        dir_table.push_back(make_request(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
                                         16'h7FFF, 11'h000, 11'h7FF));
        dir_table.push_back(make_request(16'hFF00, 16'h0000, 16'hFE00, 16'h0, 16'h0,
                                         16'hC000, 11'd512, 11'd700));
        dir_table.push_back(make_request(16'h0000, 16'h0000, 16'h0000, 16'h0, 16'h0,
                                         16'h0, 11'd0, 11'd0));
        foreach (dir_table[i]) send_request(dir_table[i]);
        drain();
        set_light(12'hFFF, 12'hFFF, 12'hFFF, 16'h7FFF, 16'h8000, 16'h0000, 8'd0);
        foreach (dir_table[i]) send_request(dir_table[i]);
        drain();
        set_light(12'h0, 12'h800, 12'hFFF, 16'h8000, 16'h7FFF, 16'h8000, 8'd128);
        foreach (dir_table[i]) send_request(dir_table[i]);
        drain();
        set_light(12'd1024, 12'd1024, 12'd1024, 16'h0000, 16'h0000, 16'h0000, 8'd255);
        foreach (dir_table[i]) send_request(dir_table[i]);
        drain();
        // An unused register index must change nothing.
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);

        for (int phase = 0; phase < 5; phase++) begin
            set_light(12'($urandom), 12'($urandom), 12'($urandom),
                      16'($signed($urandom_range(4096)) - 2048),
                      16'($signed($urandom_range(4096)) - 2048),
                      ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0000,
                      (phase == 4) ? 8'($urandom) : 8'($urandom_range(128, 1)));
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 74; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 74; end
                3: begin send_idle_pct = 26; stall_pct = 26; end
                default: begin send_idle_pct = 0; stall_pct = 10; end
            endcase
            if (phase == 4) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(negedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            repeat (160) send_request(rand_request());
            drain();
        end

        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: point_light_phong_shading.f
sv/plps_pkg.sv
sv/point_light_phong_shading.sv
tb/tb_point_light_phong_shading.sv
